[design/srfp_pkg.sv]
package srfp_pkg;

    // history is stored as byte pairs, one pair per cell
    localparam int HIST_DEPTH = 56;
    localparam int CELL_COUNT = HIST_DEPTH / 2;

    localparam int DEF_SAMPLE_COUNT = 25;
    localparam int DEF_MIN_PREFIX   = 57;

    // count of bytes seen before the last tag byte
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // wait after a tag: the running max is handed through every cell, then latched
    localparam int WAIT_LEN = CELL_COUNT + 1;
    localparam int WAIT_W   = $clog2(WAIT_LEN + 1);

    localparam int MAG_W = 15;

    // tag "Bdata"
    localparam logic [7:0] TAG_B = 8'h42;
    localparam logic [7:0] TAG_D = 8'h64;
    localparam logic [7:0] TAG_A = 8'h61;
    localparam logic [7:0] TAG_T = 8'h74;

    localparam logic [7:0] STATUS_OFF_BED = 8'd1;

    // link between neighboring cells
    typedef struct packed {
        logic [7:0]       data;
        logic [MAG_W-1:0] peak;
    } t_link;

    // magnitude of a signed word; the most negative value counts as zero
    function automatic logic [MAG_W-1:0] word_mag(input logic [15:0] w);
        logic [15:0] neg;
        neg = 16'(~w + 16'd1);
        if (w == 16'h8000) begin
            word_mag = '0;
        end else if (w[15]) begin
            word_mag = neg[MAG_W-1:0];
        end else begin
            word_mag = w[MAG_W-1:0];
        end
    endfunction

endpackage

[design/srfp_rx_if.sv]
interface srfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/srfp_res_if.sv]
interface srfp_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  seq_byte;
    logic [7:0]  bed_status;
    logic [7:0]  pulse_bpm;
    logic [7:0]  breathing_tenths;
    logic signed [15:0] pressure;
    logic [14:0] piezo_peak;
    logic        full_frame;

    modport source (output valid, output seq_byte, output bed_status,
                    output pulse_bpm, output breathing_tenths, output pressure,
                    output piezo_peak, output full_frame, input ready);
    modport sink   (input valid, input seq_byte, input bed_status,
                    input pulse_bpm, input breathing_tenths, input pressure,
                    input piezo_peak, input full_frame, output ready);
endinterface

[design/srfp_cell.sv]
// Two history bytes plus one stage of the running peak.
module srfp_cell (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic                       i_use,
    input  srfp_pkg::t_link            i_link,
    output srfp_pkg::t_link            o_link,
    output logic [15:0]                o_word
);
    logic [7:0]                  r_newer;
    logic [7:0]                  r_older;
    logic [srfp_pkg::MAG_W-1:0]  r_peak;
    logic [srfp_pkg::MAG_W-1:0]  n_peak;
    logic [srfp_pkg::MAG_W-1:0]  w_mag;

    // older byte is the low half of the sample
    assign o_word = {r_newer, r_older};
    assign w_mag  = srfp_pkg::word_mag(o_word);

    always_comb begin
        n_peak = i_link.peak;
        if (i_use && (w_mag > i_link.peak)) begin
            n_peak = w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_newer <= i_link.data;
            r_older <= r_newer;
        end
        r_peak <= n_peak;
    end

    assign o_link.data = r_older;
    assign o_link.peak = r_peak;
endmodule

[design/sensor_result_frame_parser_top.sv]
// channel | dir | payload                                   | accepted when
// i_rx    | in  | rx_byte[7:0]                              | valid && ready
// o_res   | out | serial, status, rates, pressure, peak, full | valid && ready
//
// A byte that is not a tag's last byte starts no peak wait.
// After the last byte of a tag, input waits while the peak, a running max, is
// handed down the row of 28 cells, one cell per cycle, with the history frozen.
// Reset (i_rst_n low, synchronous) clears phase, count, wait and output valid;
// history and latched values need none, they are written before use.
// A result waits in the output register; apart from the peak wait, input stalls
// only when a fourth data byte arrives while that register is still full.
module sensor_result_frame_parser_top #(
    parameter int SAMPLE_COUNT = srfp_pkg::DEF_SAMPLE_COUNT,
    parameter int MIN_PREFIX   = srfp_pkg::DEF_MIN_PREFIX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srfp_rx_if.sink     i_rx,
    srfp_res_if.source  o_res
);
    localparam int CC = srfp_pkg::CELL_COUNT;

    // data phase codes
    localparam logic [2:0] PH_SEARCH = 3'd0;
    localparam logic [2:0] PH_D1     = 3'd1;
    localparam logic [2:0] PH_D2     = 3'd2;
    localparam logic [2:0] PH_D3     = 3'd3;
    localparam logic [2:0] PH_D4     = 3'd4;

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [2:0]                  r_phase, n_phase;
    logic [srfp_pkg::CNT_W-1:0]  r_cnt,   n_cnt;
    logic [srfp_pkg::WAIT_W-1:0] r_wait,  n_wait;
    logic                        r_ov,    n_ov;

    // payload registers
    logic [7:0]  r_hist0;          // newest history byte
    logic [7:0]  r_data [3];       // first three data bytes
    logic        r_full;
    logic [15:0] r_pres;
    logic [srfp_pkg::MAG_W-1:0] r_peak;

    logic [7:0]  r_o_serial, r_o_status, r_o_hr, r_o_br;
    logic [15:0] r_o_pres;
    logic [srfp_pkg::MAG_W-1:0] r_o_peak;
    logic        r_o_full;

    // ---------------------------------------------------------------
    // Row of cells: cell c holds history bytes 2c+1 and 2c+2
    // ---------------------------------------------------------------
    srfp_pkg::t_link w_link [CC+1];
    logic [15:0]     w_word [CC];
    logic            w_accept;

    assign w_link[0].data = r_hist0;
    assign w_link[0].peak = '0;

    for (genvar c = 0; c < CC; c++) begin : g_cell
        srfp_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_accept),
            .i_use  (c >= CC - SAMPLE_COUNT),
            .i_link (w_link[c]),
            .o_link (w_link[c+1]),
            .o_word (w_word[c])
        );
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic       w_searching;
    logic       w_tag;
    logic       w_full_now;
    logic       w_emit;
    logic       w_off_bed;
    logic [7:0] b;

    assign b           = i_rx.rx_byte;
    assign w_searching = (r_phase != PH_D1) && (r_phase != PH_D2) &&
                         (r_phase != PH_D3) && (r_phase != PH_D4);

    assign i_rx.ready = (r_wait == '0) &&
                        ((r_phase != PH_D4) || !r_ov || o_res.ready);
    assign w_accept   = i_rx.valid && i_rx.ready;

    // tag bytes: history 3..0 = B d a t, incoming = a (word high byte = newer)
    assign w_tag = (b == srfp_pkg::TAG_A) &&
                   (r_hist0 == srfp_pkg::TAG_T) &&
                   (w_word[0][15:8] == srfp_pkg::TAG_A) &&
                   (w_word[0][7:0]  == srfp_pkg::TAG_D) &&
                   (w_word[1][15:8] == srfp_pkg::TAG_B) &&
                   (r_cnt >= srfp_pkg::CNT_W'(4));

    // prefix = count - 4 >= MIN_PREFIX
    assign w_full_now = ({1'b0, r_cnt} >= (srfp_pkg::CNT_W+1)'(MIN_PREFIX + 4));

    assign w_emit    = w_accept && (r_phase == PH_D4);
    assign w_off_bed = (r_data[1] == srfp_pkg::STATUS_OFF_BED);

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_wait  = r_wait;
        n_ov    = r_ov;
        if (r_wait != '0) begin
            n_wait = r_wait - 1'b1;
        end
        if (o_res.ready) begin
            n_ov = 1'b0;
        end
        if (w_accept) begin
            unique case (r_phase)
                PH_D1:   n_phase = PH_D2;
                PH_D2:   n_phase = PH_D3;
                PH_D3:   n_phase = PH_D4;
                PH_D4: begin
                    n_phase = PH_SEARCH;
                    n_cnt   = '0;
                    n_ov    = 1'b1;
                end
                default: begin
                    if (w_tag) begin
                        n_phase = PH_D1;
                        n_wait  = srfp_pkg::WAIT_W'(srfp_pkg::WAIT_LEN);
                    end else begin
                        n_phase = PH_SEARCH;
                        if (r_cnt != srfp_pkg::CNT_MAX) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_cnt   <= '0;
            r_wait  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_wait  <= n_wait;
            r_ov    <= n_ov;
        end
    end

    // ---------------------------------------------------------------
    // Payload
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hist0 <= b;
            case (r_phase)
                PH_D1:   r_data[0] <= b;
                PH_D2:   r_data[1] <= b;
                PH_D3:   r_data[2] <= b;
                default: ;
            endcase
            if (w_searching && w_tag) begin
                r_full <= w_full_now;
            end
        end
        // end of wait: history shifted once past the tag, so the pressure
        // pair sits in cell 2 and the peak has reached the last cell
        if (r_wait == srfp_pkg::WAIT_W'(1)) begin
            r_pres <= r_full ? w_word[2] : 16'd0;
            r_peak <= r_full ? w_link[CC].peak : '0;
        end
        if (w_emit) begin
            r_o_serial <= r_data[0];
            r_o_status <= r_data[1];
            r_o_hr     <= w_off_bed ? 8'd0 : r_data[2];
            r_o_br     <= w_off_bed ? 8'd0 : b;
            r_o_pres   <= r_pres;
            r_o_peak   <= r_peak;
            r_o_full   <= r_full;
        end
    end

    assign o_res.valid            = r_ov;
    assign o_res.seq_byte         = r_o_serial;
    assign o_res.bed_status       = r_o_status;
    assign o_res.pulse_bpm        = r_o_hr;
    assign o_res.breathing_tenths = r_o_br;
    assign o_res.pressure         = r_o_pres;
    assign o_res.piezo_peak       = r_o_peak;
    assign o_res.full_frame       = r_o_full;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_tag_starts_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_searching && w_tag)
        |=> (r_wait == srfp_pkg::WAIT_W'(srfp_pkg::WAIT_LEN)))
        else $error("tag did not start the peak wait");

    a_history_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait != '0) |=> $stable(r_hist0))
        else $error("history moved during peak wait");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_ov && (r_phase == PH_SEARCH) && (r_cnt == '0)))
        else $error("result not presented after fourth data byte");

    a_wait_only_in_d1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait != '0) |-> (r_phase == PH_D1))
        else $error("peak wait outside first data phase");
endmodule
